>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while in reset.
`define AMF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while in reset.
`define AMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/amf_pkg.sv
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types and constants of the antenna measurement frame unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amf_pkg;

  // Geometry
  localparam int NUM_CHANNELS             = 6;
  localparam int SAMPLES_PER_CHANNEL_DEF  = 16;
  localparam int ADC_W                    = 12;
  localparam int ADC_MAX                  = (1 << ADC_W) - 1;
  localparam int CHAN_W                   = 3;
  localparam int SUM_W                    = 16;
  localparam int MV_W                     = 12;
  localparam int CFG_W                    = 12;
  localparam int CFG_IDX_W                = 2;
  localparam int VX10_W                   = 16;
  localparam int IX100_W                  = 16;
  localparam int RATIO_W                  = 8;
  localparam int CLASS_W                  = 2;
  localparam int SUPPLY_W                 = 15;

  // Divider operand widths (magnitudes)
  localparam int DIV_NUM_W = 23;
  localparam int DIV_DEN_W = 16;

  // Channel tags
  localparam logic [CHAN_W-1:0] CH_VOLT   = 3'd0;
  localparam logic [CHAN_W-1:0] CH_SUPPLY = 3'd1;
  localparam logic [CHAN_W-1:0] CH_FWD    = 3'd2;
  localparam logic [CHAN_W-1:0] CH_REV    = 3'd3;
  localparam logic [CHAN_W-1:0] CH_CURR   = 3'd4;
  localparam logic [CHAN_W-1:0] CH_TEMP   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_HI = 2'd3;

  localparam logic [CFG_W-1:0] VOLT_LO_RST = 12'd0;
  localparam logic [CFG_W-1:0] VOLT_HI_RST = 12'd2000;
  localparam logic [CFG_W-1:0] CURR_LO_RST = 12'd0;
  localparam logic [CFG_W-1:0] CURR_HI_RST = 12'd2000;

  // Impedance class codes
  localparam logic [CLASS_W-1:0] CLS_LOW   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_MATCH = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_HIGH  = 2'd2;

  // Scaling constants
  localparam int MV_FULL_SCALE   = 2500;
  localparam int SUPPLY_GAIN_X10 = 110;
  localparam int IMP_REF_OHMS    = 50;
  localparam int RATIO_MAX       = 255;
  localparam int CLASS_LOW_LIM   = 40;
  localparam int CLASS_HIGH_LIM  = 60;
  localparam int LOW_VOLT_MV     = 5;
  localparam int VCAL_A          = 585;
  localparam int VCAL_B          = 122;
  localparam int ICAL_A          = 1185;
  localparam int ICAL_B          = 225;
  localparam int ICAL_SCALE      = 10;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_stat_t;

  function automatic int floor_log2(input int n);
    int v;
    int s;
    v = n;
    s = 0;
    for (int k = 0; k < 16; k++) begin
      if (v > 1) begin
        v = v >> 1;
        s = s + 1;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/amf_if.sv
// ----------------------------------------------------------------------------
// amf_if
// Valid/ready channels for measurement samples and frame reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface amf_meas_if;
  import amf_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADC_W-1:0]  sample;
  logic [CHAN_W-1:0] chan;
  logic              frame_end;
  logic              phase_pin;

  modport source (output valid, sample, chan, frame_end, phase_pin, input ready);
  modport sink   (input valid, sample, chan, frame_end, phase_pin, output ready);
endinterface

interface amf_report_if;
  import amf_pkg::*;

  logic                valid;
  logic                ready;
  logic [VX10_W-1:0]   ant_volts_x10;
  logic [IX100_W-1:0]  ant_amps_x100;
  logic [RATIO_W-1:0]  impedance_ratio;
  logic [CLASS_W-1:0]  impedance_class;
  logic                phase_negative;
  logic [SUPPLY_W-1:0] supply_mv;
  logic [MV_W-1:0]     forward_mv;
  logic [MV_W-1:0]     reverse_mv;
  logic [MV_W-1:0]     temperature_mv;
  logic [MV_W-1:0]     volt_mv;
  logic [MV_W-1:0]     curr_mv;

  modport source (
    output valid, ant_volts_x10, ant_amps_x100, impedance_ratio, impedance_class,
           phase_negative, supply_mv, forward_mv, reverse_mv, temperature_mv,
           volt_mv, curr_mv,
    input  ready
  );
  modport sink (
    input  valid, ant_volts_x10, ant_amps_x100, impedance_ratio, impedance_class,
           phase_negative, supply_mv, forward_mv, reverse_mv, temperature_mv,
           volt_mv, curr_mv,
    output ready
  );
endinterface

`default_nettype wire

>>> src/amf_div.sv
// ----------------------------------------------------------------------------
// amf_div
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amf_div (
  input  logic               clk,
  input  logic               rst,
  input  amf_pkg::div_req_t  req,
  output amf_pkg::div_stat_t stat
);
  import amf_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_next;
  logic                 ge;

  // Bring down the next dividend bit; quotient bits shift in from the right.
  assign rem_sh   = {rem, quo[DIV_NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quot = quo;

endmodule

`default_nettype wire

>>> src/antenna_measurement_frame_unit.sv
// A sample beat reads the channel sum from the sum memory in the accept cycle and
// writes the saturated sum back in the next. A frame-end beat then runs a sweep over
// the six sums (read, then scale to millivolts), followed by three passes of one
// shared bit-serial divider (voltage calibration, current calibration, impedance
// ratio), each a start, a shift step per quotient bit and a done. A pass ends in its
// start state when its span or the current is zero. The report is then loaded into
// the report register once that is free, and the next beat is taken from then on.
// The sums need no clearing pass: a valid bit per entry, cleared by reset and at
// each frame end, makes an entry read as zero until it is written again.
// ----------------------------------------------------------------------------
// antenna_measurement_frame_unit
// Per-channel sample accumulation and frame-end antenna measurement report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module antenna_measurement_frame_unit #(
  parameter int SAMPLES_PER_CHANNEL = amf_pkg::SAMPLES_PER_CHANNEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [amf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amf_pkg::CFG_W-1:0]      cfg_data,
  amf_meas_if.sink                       meas,
  amf_report_if.source                   report
);
  import amf_pkg::*;

  localparam int AVG_SHIFT   = floor_log2(SAMPLES_PER_CHANNEL);
  localparam int ADDR_W      = $clog2(NUM_CHANNELS);
  localparam int PROD_W      = 2 * ADC_W;
  localparam int SUPPLY_GAIN = SUPPLY_GAIN_X10 / 10;
  localparam int NUM_SW      = DIV_NUM_W + 2;
  localparam int DEN_SW      = DIV_DEN_W + 1;
  localparam int DIF_W       = CFG_W + 1;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_ACC        = 11'b000_0000_0010,
    S_SWP_RD     = 11'b000_0000_0100,
    S_SWP_CAP    = 11'b000_0000_1000,
    S_VOLT       = 11'b000_0001_0000,
    S_VOLT_WAIT  = 11'b000_0010_0000,
    S_CURR       = 11'b000_0100_0000,
    S_CURR_WAIT  = 11'b000_1000_0000,
    S_RATIO      = 11'b001_0000_0000,
    S_RATIO_WAIT = 11'b010_0000_0000,
    S_OUT        = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration
  logic [CFG_W-1:0] volt_lo;
  logic [CFG_W-1:0] volt_hi;
  logic [CFG_W-1:0] curr_lo;
  logic [CFG_W-1:0] curr_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_lo <= VOLT_LO_RST;
      volt_hi <= VOLT_HI_RST;
      curr_lo <= CURR_LO_RST;
      curr_hi <= CURR_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLT_LO: volt_lo <= cfg_data;
        REG_VOLT_HI: volt_hi <= cfg_data;
        REG_CURR_LO: curr_lo <= cfg_data;
        REG_CURR_HI: curr_hi <= cfg_data;
      endcase
    end
  end

  // Accepted beat
  logic              accept;
  logic              chan_ok;
  logic [ADC_W-1:0]  it_sample;
  logic [ADDR_W-1:0] it_chan;
  logic              it_ok;
  logic              it_fe;
  logic              it_phase;

  assign meas.ready = (state == S_IDLE);
  assign accept     = meas.valid && meas.ready;
  assign chan_ok    = meas.chan < CHAN_W'(NUM_CHANNELS);

  always_ff @(posedge clk) begin
    if (accept) begin
      it_sample <= meas.sample;
      it_chan   <= chan_ok ? ADDR_W'(meas.chan) : '0;
      it_ok     <= chan_ok;
      it_fe     <= meas.frame_end;
      it_phase  <= meas.phase_pin;
    end
  end

  // Sum memory with a registered read. A write in the accumulate state is always
  // done before the next read that is used, so no forwarding.
  logic [SUM_W-1:0]        sums [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic                    rd_vld;
  logic [SUM_W-1:0]        mem_rdata;
  logic [ADDR_W-1:0]       mem_raddr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       swp;
  logic [SUM_W-1:0]        sum_cur;
  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        sum_sat;

  assign mem_raddr = (state == S_SWP_RD) ? swp :
                     (chan_ok ? ADDR_W'(meas.chan) : '0);
  assign mem_we    = (state == S_ACC) && it_ok;
  assign sum_cur   = rd_vld ? mem_rdata : '0;
  assign sum_ext   = {1'b0, sum_cur} + (SUM_W + 1)'(it_sample);
  assign sum_sat   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums[it_chan] <= sum_sat;
    end
    mem_rdata <= sums[mem_raddr];
    rd_vld    <= vld[mem_raddr];
  end

  // Average and scale to millivolts
  logic [SUM_W-1:0]  avg_full;
  logic [ADC_W-1:0]  avg_clip;
  logic [PROD_W-1:0] mv_prod;
  logic [MV_W-1:0]   mv_cap;
  logic [MV_W-1:0]   mv_ch [NUM_CHANNELS];

  assign avg_full = sum_cur >> AVG_SHIFT;
  assign avg_clip = (avg_full > SUM_W'(ADC_MAX)) ? ADC_W'(ADC_MAX) : avg_full[ADC_W-1:0];
  assign mv_prod  = PROD_W'(avg_clip) * PROD_W'(MV_FULL_SCALE);
  assign mv_cap   = MV_W'(mv_prod >> ADC_W);

  always_ff @(posedge clk) begin
    if (state == S_SWP_CAP) begin
      mv_ch[swp] <= mv_cap;
    end
  end

  // Low-level zeroing
  logic            low_volt;
  logic [MV_W-1:0] u_mv;
  logic [MV_W-1:0] i_mv;

  assign low_volt = mv_ch[CH_VOLT] < MV_W'(LOW_VOLT_MV);
  assign u_mv     = low_volt ? '0 : mv_ch[CH_VOLT];
  assign i_mv     = low_volt ? '0 : mv_ch[CH_CURR];

  // Calibration operands
  logic signed [DIF_W-1:0]  dv;
  logic signed [DIF_W-1:0]  di;
  logic signed [DIF_W-1:0]  du_m;
  logic signed [DIF_W-1:0]  di_m;
  logic signed [NUM_SW-1:0] num_v;
  logic signed [NUM_SW-1:0] num_i;
  logic signed [DEN_SW-1:0] den_i;
  logic signed [NUM_SW-1:0] num_sel;
  logic signed [DEN_SW-1:0] den_sel;
  logic [NUM_SW-1:0]        num_mag;
  logic [DEN_SW-1:0]        den_mag;

  assign dv    = $signed({1'b0, volt_hi}) - $signed({1'b0, volt_lo});
  assign di    = $signed({1'b0, curr_hi}) - $signed({1'b0, curr_lo});
  assign du_m  = $signed({1'b0, u_mv}) - $signed({1'b0, volt_lo});
  assign di_m  = $signed({1'b0, i_mv}) - $signed({1'b0, curr_lo});
  assign num_v = NUM_SW'(VCAL_A) * NUM_SW'(du_m) + NUM_SW'(VCAL_B) * NUM_SW'(dv);
  assign num_i = NUM_SW'(ICAL_A) * NUM_SW'(di_m) + NUM_SW'(ICAL_B) * NUM_SW'(di);
  assign den_i = DEN_SW'(ICAL_SCALE) * DEN_SW'(di);

  assign num_sel = (state == S_CURR) ? num_i : num_v;
  assign den_sel = (state == S_CURR) ? den_i : DEN_SW'(dv);
  assign num_mag = num_sel[NUM_SW-1] ? NUM_SW'(-num_sel) : NUM_SW'(num_sel);
  assign den_mag = den_sel[DEN_SW-1] ? DEN_SW'(-den_sel) : DEN_SW'(den_sel);

  // Shared divider
  div_req_t  div_req;
  div_stat_t div_stat;
  logic      div_neg;

  assign div_req.start = ((state == S_VOLT)  && (dv != '0)) ||
                         ((state == S_CURR)  && (di != '0)) ||
                         ((state == S_RATIO) && (i_mv != '0));
  assign div_req.num   = (state == S_RATIO) ?
                         DIV_NUM_W'(DIV_NUM_W'(u_mv) * DIV_NUM_W'(IMP_REF_OHMS)) :
                         num_mag[DIV_NUM_W-1:0];
  assign div_req.den   = (state == S_RATIO) ? DIV_DEN_W'(i_mv) : den_mag[DIV_DEN_W-1:0];

  amf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  // Negative quotients clamp to zero, large ones to full scale.
  function automatic logic [VX10_W-1:0] sat_quot(input logic neg,
                                                 input logic [DIV_NUM_W-1:0] q);
    logic [VX10_W-1:0] r;
    if (neg) begin
      r = '0;
    end else if (q > DIV_NUM_W'({VX10_W{1'b1}})) begin
      r = '1;
    end else begin
      r = q[VX10_W-1:0];
    end
    return r;
  endfunction

  logic [VX10_W-1:0]  vx10;
  logic [IX100_W-1:0] ix100;
  logic [RATIO_W-1:0] ratio;
  logic [CLASS_W-1:0] ratio_cls;

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      div_neg <= num_sel[NUM_SW-1] ^ den_sel[DEN_SW-1];
    end
    case (state)
      S_VOLT: begin
        if (dv == '0) vx10 <= '0;
      end
      S_VOLT_WAIT: begin
        if (div_stat.done) vx10 <= sat_quot(div_neg, div_stat.quot);
      end
      S_CURR: begin
        if (di == '0) ix100 <= '0;
      end
      S_CURR_WAIT: begin
        if (div_stat.done) ix100 <= sat_quot(div_neg, div_stat.quot);
      end
      S_RATIO: begin
        if (i_mv == '0) ratio <= RATIO_W'(RATIO_MAX);
      end
      S_RATIO_WAIT: begin
        if (div_stat.done) begin
          ratio <= (div_stat.quot > DIV_NUM_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) :
                   div_stat.quot[RATIO_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign ratio_cls = (ratio < RATIO_W'(CLASS_LOW_LIM))  ? CLS_LOW  :
                     (ratio > RATIO_W'(CLASS_HIGH_LIM)) ? CLS_HIGH : CLS_MATCH;

  // Report register
  logic out_valid;
  logic out_load;

  assign out_load = (state == S_OUT) && (!out_valid || report.ready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      report.ant_volts_x10   <= vx10;
      report.ant_amps_x100   <= ix100;
      report.impedance_ratio <= ratio;
      report.impedance_class <= ratio_cls;
      report.phase_negative  <= it_phase;
      report.supply_mv       <= SUPPLY_W'(mv_ch[CH_SUPPLY]) * SUPPLY_W'(SUPPLY_GAIN);
      report.forward_mv      <= mv_ch[CH_FWD];
      report.reverse_mv      <= mv_ch[CH_REV];
      report.temperature_mv  <= mv_ch[CH_TEMP];
      report.volt_mv         <= u_mv;
      report.curr_mv         <= i_mv;
    end
  end

  assign report.valid = out_valid;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (accept) state_next = S_ACC;
      S_ACC:        state_next = it_fe ? S_SWP_RD : S_IDLE;
      S_SWP_RD:     state_next = S_SWP_CAP;
      S_SWP_CAP:    state_next = (swp == ADDR_W'(NUM_CHANNELS - 1)) ? S_VOLT : S_SWP_RD;
      S_VOLT:       state_next = div_req.start ? S_VOLT_WAIT : S_CURR;
      S_VOLT_WAIT:  if (div_stat.done) state_next = S_CURR;
      S_CURR:       state_next = div_req.start ? S_CURR_WAIT : S_RATIO;
      S_CURR_WAIT:  if (div_stat.done) state_next = S_RATIO;
      S_RATIO:      state_next = div_req.start ? S_RATIO_WAIT : S_OUT;
      S_RATIO_WAIT: if (div_stat.done) state_next = S_OUT;
      S_OUT:        if (out_load) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      swp       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        vld[it_chan] <= 1'b1;
      end
      if (state == S_ACC) begin
        swp <= '0;
      end else if (state == S_SWP_CAP) begin
        swp <= swp + ADDR_W'(1);
        // last sum read: drop the whole frame
        if (swp == ADDR_W'(NUM_CHANNELS - 1)) begin
          vld <= '0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (report.valid && report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  `AMF_ASSERT_IMPL(a_class_low, report.valid, (report.impedance_class == CLS_LOW) == (report.impedance_ratio < RATIO_W'(CLASS_LOW_LIM)), "impedance class disagrees with ratio")
  `AMF_ASSERT_IMPL(a_zero_volt, report.valid && (report.volt_mv == '0), report.curr_mv == '0, "current not zeroed with voltage")
  `AMF_ASSERT_IMPL(a_no_curr, report.valid && (report.curr_mv == '0), report.impedance_ratio == RATIO_W'(RATIO_MAX), "ratio not at full scale without current")
  `AMF_ASSERT_IMPL(a_div_free, div_req.start, !div_stat.busy, "divider started while busy")
  `AMF_ASSERT_NEXT(a_one_beat, accept, !meas.ready, "second beat taken before sum write-back")

endmodule

`default_nettype wire

>>> test/antenna_measurement_frame_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antenna_measurement_frame_unit_test
// Streams tagged samples into the frame unit under random source and sink
// stalls, across several calibration settings. Each frame report is checked
// field by field against a behavioral model of accumulation, scaling,
// calibration and impedance classification kept inside this bench.
// ----------------------------------------------------------------------------

module antenna_measurement_frame_unit_test;
  import amf_pkg::*;

  localparam int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF;
  localparam int AVG_SHIFT = $clog2(SAMPLES_PER_CHANNEL + 1) - 1;
  localparam int SUM_MAX = (1 << SUM_W) - 1;
  localparam int CAL_MAX = (1 << VX10_W) - 1;
  localparam int PHASES = 8;
  localparam int FIXED_SETS = 5;
  localparam int PHASE_BEATS = 210;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int DIRECTED_ROWS = 22;

  // Tags outside the six measured channels
  localparam logic [CHAN_W-1:0] CH_SPARE  = 3'd6;
  localparam logic [CHAN_W-1:0] CH_UNUSED = 3'd7;

  typedef struct packed {
    logic [ADC_W-1:0]  sample;
    logic [CHAN_W-1:0] chan;
    logic              frame_end;
    logic              phase_pin;
  } meas_t;

  typedef struct packed {
    logic [VX10_W-1:0]   ant_volts_x10;
    logic [IX100_W-1:0]  ant_amps_x100;
    logic [RATIO_W-1:0]  impedance_ratio;
    logic [CLASS_W-1:0]  impedance_class;
    logic                phase_negative;
    logic [SUPPLY_W-1:0] supply_mv;
    logic [MV_W-1:0]     forward_mv;
    logic [MV_W-1:0]     reverse_mv;
    logic [MV_W-1:0]     temperature_mv;
    logic [MV_W-1:0]     volt_mv;
    logic [MV_W-1:0]     curr_mv;
  } report_t;

  typedef struct packed {
    meas_t      beat;
    logic [7:0] reps;    // beat repeated; frame_end only on the last copy
    logic       fixed;   // expected report given below
    report_t    want;
  } directed_row_t;

  // Empty or zeroed frame at reset calibration
  localparam report_t ZERO_FRAME = '{16'd122, 16'd22, 8'd255, CLS_HIGH, 1'b0, 15'd0,
                                     12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
  localparam report_t ZERO_FRAME_NEG = '{16'd122, 16'd22, 8'd255, CLS_HIGH, 1'b1, 15'd0,
                                         12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
  // Every channel saturated at reset calibration
  localparam report_t FULL_SCALE_FRAME = '{16'd852, 16'd170, 8'd50, CLS_MATCH, 1'b1,
                                           15'd27489, 12'd2499, 12'd2499, 12'd2499,
                                           12'd2499, 12'd2499};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  amf_meas_if   meas_bus ();
  amf_report_if report_bus ();

  antenna_measurement_frame_unit #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .meas      (meas_bus),
    .report    (report_bus)
  );

  always #5 clk = ~clk;

  // Model state
  logic [SUM_W-1:0] chan_sums [NUM_CHANNELS];
  logic [CFG_W-1:0] cal_volt_lo = VOLT_LO_RST;
  logic [CFG_W-1:0] cal_volt_hi = VOLT_HI_RST;
  logic [CFG_W-1:0] cal_curr_lo = CURR_LO_RST;
  logic [CFG_W-1:0] cal_curr_hi = CURR_HI_RST;

  report_t pending_reports [$];
  meas_t   frame_beats [$];
  int fail_count = 0;
  int beats_sent = 0;
  int idle_cycles = 0;

  function automatic int unsigned channel_mv(input int c);
    int unsigned avg;
    avg = chan_sums[c] >> AVG_SHIFT;
    if (avg > ADC_MAX) avg = ADC_MAX;
    return (avg * MV_FULL_SCALE) / (ADC_MAX + 1);
  endfunction

  // Two-point calibration, quotient truncated toward zero, then clamped
  function automatic logic [VX10_W-1:0] calibrated(input int m, input int lo, input int hi,
                                                    input int a, input int b, input int scale);
    longint span;
    longint num;
    longint quo;
    span = longint'(hi) - longint'(lo);
    if (span == 0) return '0;
    num = longint'(a) * (longint'(m) - longint'(lo)) + longint'(b) * span;
    quo = num / (longint'(scale) * span);
    if (quo < 0) return '0;
    if (quo > CAL_MAX) return CAL_MAX[VX10_W-1:0];
    return quo[VX10_W-1:0];
  endfunction

  function automatic report_t measure_frame(input logic phase);
    report_t r;
    int unsigned u;
    int unsigned i;
    int unsigned ratio;
    u = channel_mv(CH_VOLT);
    i = channel_mv(CH_CURR);
    if (u < LOW_VOLT_MV) begin
      u = 0;
      i = 0;
    end
    r.ant_volts_x10 = calibrated(u, cal_volt_lo, cal_volt_hi, VCAL_A, VCAL_B, 1);
    r.ant_amps_x100 = calibrated(i, cal_curr_lo, cal_curr_hi, ICAL_A, ICAL_B, ICAL_SCALE);
    if (i == 0) begin
      ratio = RATIO_MAX;
    end else begin
      ratio = (u * IMP_REF_OHMS) / i;
      if (ratio > RATIO_MAX) ratio = RATIO_MAX;
    end
    r.impedance_ratio = ratio[RATIO_W-1:0];
    if (ratio < CLASS_LOW_LIM) r.impedance_class = CLS_LOW;
    else if (ratio > CLASS_HIGH_LIM) r.impedance_class = CLS_HIGH;
    else r.impedance_class = CLS_MATCH;
    r.phase_negative = phase;
    r.supply_mv = SUPPLY_W'((channel_mv(CH_SUPPLY) * SUPPLY_GAIN_X10) / 10);
    r.forward_mv = MV_W'(channel_mv(CH_FWD));
    r.reverse_mv = MV_W'(channel_mv(CH_REV));
    r.temperature_mv = MV_W'(channel_mv(CH_TEMP));
    r.volt_mv = u[MV_W-1:0];
    r.curr_mv = i[MV_W-1:0];
    foreach (chan_sums[c]) chan_sums[c] = '0;
    return r;
  endfunction

  // Fold one accepted beat into the sums; returns 1 when it closes a frame
  function automatic bit absorb_beat(input meas_t b, output report_t r);
    int unsigned total;
    r = '0;
    if (b.chan < NUM_CHANNELS) begin
      total = chan_sums[b.chan] + b.sample;
      chan_sums[b.chan] = (total > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : total[SUM_W-1:0];
    end
    if (!b.frame_end) return 1'b0;
    r = measure_frame(b.phase_pin);
    return 1'b1;
  endfunction

  function automatic logic [ADC_W-1:0] draw_sample(input int c, input int v_base,
                                                   input int c_base);
    int s;
    if (c == CH_VOLT) s = v_base + int'($urandom_range(32)) - 16;
    else if (c == CH_CURR) s = c_base + int'($urandom_range(32)) - 16;
    else if ($urandom_range(7) == 0) s = $urandom_range(1) ? ADC_MAX : 0;
    else s = $urandom_range(ADC_MAX);
    if (s < 0) s = 0;
    if (s > ADC_MAX) s = ADC_MAX;
    return s[ADC_W-1:0];
  endfunction

  // Build one frame: full interleaved frames, short frames, or noise with
  // unused tags and at times one overfull channel
  function automatic void fill_frame();
    int kind;
    int len;
    int v_base;
    int c_base;
    int off;
    int burst_chan;
    meas_t b;
    frame_beats.delete();
    kind = $urandom_range(99);
    v_base = ($urandom_range(7) == 0) ? $urandom_range(10) : $urandom_range(ADC_MAX);
    c_base = ($urandom_range(3) == 0) ? v_base : $urandom_range(ADC_MAX);
    b = '0;
    if (kind < 25) begin
      off = $urandom_range(NUM_CHANNELS - 1);
      for (int k = 0; k < SAMPLES_PER_CHANNEL * NUM_CHANNELS; k++) begin
        b.chan = CHAN_W'((k + off) % NUM_CHANNELS);
        b.sample = draw_sample(b.chan, v_base, c_base);
        b.phase_pin = 1'($urandom_range(1));
        frame_beats.push_back(b);
      end
    end else begin
      if (kind >= 80 && $urandom_range(2) == 0) begin
        burst_chan = $urandom_range(NUM_CHANNELS - 1);
        len = SAMPLES_PER_CHANNEL + 1 + $urandom_range(7);
        for (int k = 0; k < len; k++) begin
          b.chan = CHAN_W'(burst_chan);
          b.sample = ADC_MAX[ADC_W-1:0];
          b.phase_pin = 1'($urandom_range(1));
          frame_beats.push_back(b);
        end
      end
      len = (kind < 80) ? 1 + $urandom_range(23) : 1 + $urandom_range(29);
      for (int k = 0; k < len; k++) begin
        b.chan = (kind < 80) ? CHAN_W'($urandom_range(NUM_CHANNELS - 1))
                             : CHAN_W'($urandom_range(7));
        b.sample = draw_sample(b.chan, v_base, c_base);
        b.phase_pin = 1'($urandom_range(1));
        frame_beats.push_back(b);
      end
    end
    frame_beats[frame_beats.size() - 1].frame_end = 1'b1;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the beat
  task automatic send_beat(input meas_t b, input bit steady, input bit fixed,
                           input report_t fixed_want);
    int gap;
    report_t r;
    gap = steady ? 0 : $urandom_range(15);
    if (gap > 0) begin
      meas_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_bus.valid     <= 1'b1;
    meas_bus.sample    <= b.sample;
    meas_bus.chan      <= b.chan;
    meas_bus.frame_end <= b.frame_end;
    meas_bus.phase_pin <= b.phase_pin;
    do @(posedge clk); while (!meas_bus.ready);
    beats_sent++;
    if (absorb_beat(b, r)) pending_reports.push_back(fixed ? fixed_want : r);
  endtask

  task automatic load_cal(input logic [CFG_W-1:0] v_lo, input logic [CFG_W-1:0] v_hi,
                          input logic [CFG_W-1:0] c_lo, input logic [CFG_W-1:0] c_hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VOLT_LO;
    cfg_data  <= v_lo;
    @(posedge clk);
    cfg_index <= REG_VOLT_HI;
    cfg_data  <= v_hi;
    @(posedge clk);
    cfg_index <= REG_CURR_LO;
    cfg_data  <= c_lo;
    @(posedge clk);
    cfg_index <= REG_CURR_HI;
    cfg_data  <= c_hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_volt_lo = v_lo;
    cal_volt_hi = v_hi;
    cal_curr_lo = c_lo;
    cal_curr_hi = c_hi;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : report_check
    report_t want;
    if (!rst && report_bus.valid && report_bus.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: report expected none, actual volts_x10 %0d amps_x100 %0d",
                 $time, report_bus.ant_volts_x10, report_bus.ant_amps_x100);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("ant_volts_x10", want.ant_volts_x10, report_bus.ant_volts_x10);
        check_field("ant_amps_x100", want.ant_amps_x100, report_bus.ant_amps_x100);
        check_field("impedance_ratio", want.impedance_ratio, report_bus.impedance_ratio);
        check_field("impedance_class", want.impedance_class, report_bus.impedance_class);
        check_field("phase_negative", want.phase_negative, report_bus.phase_negative);
        check_field("supply_mv", want.supply_mv, report_bus.supply_mv);
        check_field("forward_mv", want.forward_mv, report_bus.forward_mv);
        check_field("reverse_mv", want.reverse_mv, report_bus.reverse_mv);
        check_field("temperature_mv", want.temperature_mv, report_bus.temperature_mv);
        check_field("volt_mv", want.volt_mv, report_bus.volt_mv);
        check_field("curr_mv", want.curr_mv, report_bus.curr_mv);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (meas_bus.valid && meas_bus.ready) || (report_bus.valid && report_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
      $display("antenna_measurement_frame_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : report_sink
    int stall;
    bit steady;
    steady = 1'b0;
    report_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(5) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(15);
      if (stall > 0) begin
        report_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      report_bus.ready <= 1'b1;
      do @(posedge clk); while (!report_bus.valid);
    end
  end

  initial begin : stimulus
    directed_row_t rows [DIRECTED_ROWS];
    logic [CFG_W-1:0] cal_sets [FIXED_SETS][4];
    meas_t b;
    bit steady;
    int random_base;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_VOLT_LO;
    cfg_data <= '0;
    meas_bus.valid <= 1'b0;
    meas_bus.sample <= '0;
    meas_bus.chan <= CH_VOLT;
    meas_bus.frame_end <= 1'b0;
    meas_bus.phase_pin <= 1'b0;
    foreach (chan_sums[c]) chan_sums[c] = '0;

    rows = '{
      '{'{12'd0,    CH_VOLT,   1'b1, 1'b0}, 8'd1,  1'b1, ZERO_FRAME},
      '{'{12'd4095, CH_UNUSED, 1'b1, 1'b1}, 8'd1,  1'b1, ZERO_FRAME_NEG},
      '{'{12'd4095, CH_SPARE,  1'b0, 1'b0}, 8'd1,  1'b0, report_t'('0)},
      // saturate every sum
      '{'{12'd4095, CH_VOLT,   1'b0, 1'b0}, 8'd17, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_SUPPLY, 1'b0, 1'b0}, 8'd17, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_FWD,    1'b0, 1'b0}, 8'd17, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_REV,    1'b0, 1'b0}, 8'd17, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_CURR,   1'b0, 1'b0}, 8'd17, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_TEMP,   1'b1, 1'b1}, 8'd17, 1'b1, FULL_SCALE_FRAME},
      // antenna voltage under the zeroing threshold
      '{'{12'd4095, CH_CURR,   1'b0, 1'b0}, 8'd16, 1'b0, report_t'('0)},
      '{'{12'd100,  CH_VOLT,   1'b1, 1'b0}, 8'd1,  1'b1, ZERO_FRAME},
      // low ratio
      '{'{12'd200,  CH_VOLT,   1'b0, 1'b0}, 8'd16, 1'b0, report_t'('0)},
      '{'{12'd4095, CH_CURR,   1'b0, 1'b0}, 8'd16, 1'b0, report_t'('0)},
      '{'{12'd0,    CH_FWD,    1'b1, 1'b1}, 8'd1,  1'b0, report_t'('0)},
      // ratio clamped high
      '{'{12'd4095, CH_VOLT,   1'b0, 1'b0}, 8'd16, 1'b0, report_t'('0)},
      '{'{12'd32,   CH_CURR,   1'b1, 1'b0}, 8'd1,  1'b0, report_t'('0)},
      // just at the zeroing threshold
      '{'{12'd144,  CH_VOLT,   1'b1, 1'b1}, 8'd1,  1'b0, report_t'('0)},
      '{'{12'd1234, CH_SUPPLY, 1'b0, 1'b0}, 8'd3,  1'b0, report_t'('0)},
      '{'{12'd2047, CH_TEMP,   1'b0, 1'b1}, 8'd5,  1'b0, report_t'('0)},
      '{'{12'd3000, CH_REV,    1'b0, 1'b0}, 8'd2,  1'b0, report_t'('0)},
      '{'{12'd2048, CH_CURR,   1'b0, 1'b0}, 8'd4,  1'b0, report_t'('0)},
      '{'{12'd2100, CH_VOLT,   1'b1, 1'b0}, 8'd4,  1'b0, report_t'('0)}
    };

    // full span, zero span, inverted span, one-count span, mixed
    cal_sets = '{
      '{12'd0,    12'd4095, 12'd0,    12'd4095},
      '{12'd1000, 12'd1000, 12'd500,  12'd500},
      '{12'd4095, 12'd0,    12'd4095, 12'd0},
      '{12'd2000, 12'd2001, 12'd0,    12'd1},
      '{12'd2499, 12'd0,    12'd2499, 12'd2499}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[n]) begin
      steady = ($urandom_range(3) == 0);
      for (int k = 0; k < rows[n].reps; k++) begin
        b = rows[n].beat;
        if (k != rows[n].reps - 1) b.frame_end = 1'b0;
        send_beat(b, steady, rows[n].fixed, rows[n].want);
      end
    end

    random_base = beats_sent;
    for (int p = 0; p < PHASES; p++) begin
      // drain before touching calibration
      meas_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (p < FIXED_SETS) begin
        load_cal(cal_sets[p][0], cal_sets[p][1], cal_sets[p][2], cal_sets[p][3]);
      end else begin
        load_cal(CFG_W'($urandom_range(ADC_MAX)), CFG_W'($urandom_range(ADC_MAX)),
                 CFG_W'($urandom_range(ADC_MAX)), CFG_W'($urandom_range(ADC_MAX)));
      end
      while (beats_sent < random_base + (p + 1) * PHASE_BEATS) begin
        fill_frame();
        steady = ($urandom_range(4) == 0);
        foreach (frame_beats[k]) send_beat(frame_beats[k], steady, 1'b0, report_t'('0));
      end
    end

    meas_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("antenna_measurement_frame_unit: match");
    end else begin
      $display("antenna_measurement_frame_unit: mismatch");
    end
    $finish;
  end

endmodule
